>>> sv/gmtig_pkg.sv
// ----------------------------------------------------------------------------
// Grid mesh triangle index generator package
// Shared types and constants for the walk sequencer, quad queue and index
// calculation of the grid mesh triangle index generator.
// ----------------------------------------------------------------------------
package gmtig_pkg;

  // Default largest number of grid points along one side.
  localparam int unsigned MaxSideDefault = 1024;

  // Fixed field widths.
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned IdxW    = 20;

  // Register reset values.
  localparam logic [CfgW-1:0] PointsReset = 11'd50;

  // Walk phases.
  typedef enum logic [1:0] {
    PH_INNER  = 2'd0,
    PH_VWRAP  = 2'd1,
    PH_UWRAP  = 2'd2,
    PH_CORNER = 2'd3
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_POINTS_U  = 3'd0,
    CFG_POINTS_V  = 3'd1,
    CFG_JOIN_U    = 3'd2,
    CFG_JOIN_V    = 3'd3,
    CFG_TWIST_U   = 3'd4,
    CFG_TWIST_V   = 3'd5,
    CFG_CLOCKWISE = 3'd6
  } cfg_reg_e;

  // Single-bit mode flags from the configuration registers.
  typedef struct packed {
    logic join_u;
    logic join_v;
    logic twist_u;
    logic twist_v;
    logic clockwise;
  } cfg_flags_t;

  // Control part of one queued quad request.
  typedef struct packed {
    logic   exh;
    logic   last;
    phase_e phase;
  } cmd_ctl_t;

endpackage

>>> sv/gmtig_front.sv
// ----------------------------------------------------------------------------
// Grid mesh walk sequencer
// Accepts step requests, keeps the row, column and phase counters and pushes
// one quad descriptor per request into the quad queue.
// ----------------------------------------------------------------------------
module gmtig_front #(
  parameter int unsigned MaxSide = gmtig_pkg::MaxSideDefault,
  localparam int unsigned CntW   = $clog2(MaxSide),
  localparam int unsigned SideW  = $clog2(MaxSide + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   restart_i,
  input  logic [SideW-1:0]       nu_i,
  input  logic [SideW-1:0]       nv_i,
  input  gmtig_pkg::cfg_flags_t  flags_i,
  input  logic                   full_i,
  output logic                   push_o,
  output gmtig_pkg::cmd_ctl_t    push_ctl_o,
  output logic [CntW-1:0]        push_row_o,
  output logic [CntW-1:0]        push_col_o
);

  logic [CntW-1:0]   row_q, row_d, col_q, col_d;
  gmtig_pkg::phase_e phase_q, phase_d;
  logic              fin_q, fin_d;

  logic [CntW-1:0]   cur_row, cur_col;
  gmtig_pkg::phase_e cur_phase;
  logic              cur_fin;
  logic [SideW:0]    row_inc, col_inc, nu_m1, nv_m1;
  logic              accept;

  // A request is taken whenever the queue has room.
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // A restart request begins again at the first quad.
  always_comb begin
    if (restart_i) begin
      cur_row   = '0;
      cur_col   = '0;
      cur_phase = gmtig_pkg::PH_INNER;
      cur_fin   = 1'b0;
    end else begin
      cur_row   = row_q;
      cur_col   = col_q;
      cur_phase = phase_q;
      cur_fin   = fin_q;
    end
  end

  assign row_inc = (SideW + 1)'(cur_row) + (SideW + 1)'(1);
  assign col_inc = (SideW + 1)'(cur_col) + (SideW + 1)'(1);
  assign nu_m1   = (SideW + 1)'(nu_i) - (SideW + 1)'(1);
  assign nv_m1   = (SideW + 1)'(nv_i) - (SideW + 1)'(1);

  // Advance of the walk; ends are tested as "at or beyond" so it always stops.
  always_comb begin
    logic adv_row;
    row_d   = cur_row;
    col_d   = cur_col;
    phase_d = cur_phase;
    fin_d   = cur_fin;
    adv_row = 1'b0;
    if (!cur_fin) begin
      case (cur_phase)
        gmtig_pkg::PH_INNER: begin
          if (col_inc < nv_m1) begin
            col_d = CntW'(col_inc);
          end else if (flags_i.join_v) begin
            col_d   = '0;
            phase_d = gmtig_pkg::PH_VWRAP;
          end else begin
            adv_row = 1'b1;
          end
        end
        gmtig_pkg::PH_VWRAP: begin
          adv_row = 1'b1;
        end
        gmtig_pkg::PH_UWRAP: begin
          if (col_inc < nv_m1) begin
            col_d = CntW'(col_inc);
          end else if (flags_i.join_v) begin
            phase_d = gmtig_pkg::PH_CORNER;
          end else begin
            fin_d = 1'b1;
          end
        end
        default: begin
          fin_d = 1'b1;
        end
      endcase
      if (adv_row) begin
        if (row_inc < nu_m1) begin
          row_d   = CntW'(row_inc);
          col_d   = '0;
          phase_d = gmtig_pkg::PH_INNER;
        end else if (flags_i.join_u) begin
          col_d   = '0;
          phase_d = gmtig_pkg::PH_UWRAP;
        end else begin
          fin_d = 1'b1;
        end
      end
    end
  end

  // Quad descriptor for the index calculation.
  always_comb begin
    push_ctl_o.exh   = cur_fin;
    push_ctl_o.last  = !cur_fin && fin_d;
    push_ctl_o.phase = cur_phase;
    push_row_o       = cur_row;
    push_col_o       = cur_col;
  end

  // Walk state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      phase_q <= gmtig_pkg::PH_INNER;
      fin_q   <= 1'b0;
    end else if (accept) begin
      row_q   <= row_d;
      col_q   <= col_d;
      phase_q <= phase_d;
      fin_q   <= fin_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The walk only finishes on a request that carried the final quad.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fin_q) |-> $past(push_o && push_ctl_o.last))
    else $error("walk finished without a final quad");

  // A final quad always leaves the walk finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_ctl_o.last |=> fin_q)
    else $error("final quad did not finish the walk");
`endif

endmodule

>>> sv/gmtig_queue.sv
// ----------------------------------------------------------------------------
// Quad queue
// Two-entry queue of quad descriptors between the walk sequencer and the
// index calculation, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module gmtig_queue #(
  parameter int unsigned CntW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gmtig_pkg::cmd_ctl_t push_ctl_i,
  input  logic [CntW-1:0]     push_row_i,
  input  logic [CntW-1:0]     push_col_i,
  output logic                full_o,
  input  logic                pop_i,
  output gmtig_pkg::cmd_ctl_t pop_ctl_o,
  output logic [CntW-1:0]     pop_row_o,
  output logic [CntW-1:0]     pop_col_o,
  output logic                empty_o
);

  gmtig_pkg::cmd_ctl_t ctl_q [2];
  logic [CntW-1:0]     row_q [2];
  logic [CntW-1:0]     col_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_ctl_o = ctl_q[rd_ptr_q];
  assign pop_row_o = row_q[rd_ptr_q];
  assign pop_col_o = col_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_q[wr_ptr_q] <= push_ctl_i;
      row_q[wr_ptr_q] <= push_row_i;
      col_q[wr_ptr_q] <= push_col_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count overflow");

  // Entries are only removed when present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");
`endif

endmodule

>>> sv/gmtig_back.sv
// ----------------------------------------------------------------------------
// Quad index calculation
// Turns a quad descriptor into the six vertex indices of its two triangles
// and holds them in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module gmtig_back #(
  parameter int unsigned MaxSide = gmtig_pkg::MaxSideDefault,
  localparam int unsigned CntW   = $clog2(MaxSide),
  localparam int unsigned SideW  = $clog2(MaxSide + 1),
  localparam int unsigned RawW   = 2 * SideW + 1,
  localparam int unsigned AccW   = (RawW > gmtig_pkg::IdxW) ? RawW : gmtig_pkg::IdxW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [SideW-1:0]            nu_i,
  input  logic [SideW-1:0]            nv_i,
  input  gmtig_pkg::cfg_flags_t       flags_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  gmtig_pkg::cmd_ctl_t         pop_ctl_i,
  input  logic [CntW-1:0]             pop_row_i,
  input  logic [CntW-1:0]             pop_col_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gmtig_pkg::IdxW-1:0]  tri0_first_o,
  output logic [gmtig_pkg::IdxW-1:0]  tri0_second_o,
  output logic [gmtig_pkg::IdxW-1:0]  tri0_third_o,
  output logic [gmtig_pkg::IdxW-1:0]  tri1_first_o,
  output logic [gmtig_pkg::IdxW-1:0]  tri1_second_o,
  output logic [gmtig_pkg::IdxW-1:0]  tri1_third_o,
  output logic                        last_o,
  output logic                        exhausted_o
);

  localparam int unsigned IdxW = gmtig_pkg::IdxW;

  logic [CntW+SideW-1:0]  row_prod;
  logic [2*SideW-1:0]     lrb_prod;
  logic [AccW-1:0]        row_base, next_base, last_base, nv_w, nv_m1, col_w;
  logic [AccW-1:0]        qa, qb, qc, qd;
  logic [IdxW-1:0]        t0f_d, t0s_d, t0t_d, t1f_d, t1s_d, t1t_d;
  logic [IdxW-1:0]        t0f_q, t0s_q, t0t_q, t1f_q, t1s_q, t1t_q;
  logic                   last_q, exh_q, valid_q;

  // The output register takes a new quad when empty or being drained.
  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  // Row base products.
  assign row_prod  = (CntW + SideW)'(pop_row_i) * (CntW + SideW)'(nv_i);
  assign lrb_prod  = (2 * SideW)'(nu_i - SideW'(1)) * (2 * SideW)'(nv_i);
  assign nv_w      = AccW'(nv_i);
  assign nv_m1     = nv_w - AccW'(1);
  assign col_w     = AccW'(pop_col_i);
  assign row_base  = AccW'(row_prod);
  assign next_base = row_base + nv_w;
  assign last_base = AccW'(lrb_prod);

  // Quad corners for each phase of the walk.
  always_comb begin
    qa = '0;
    qb = '0;
    qc = '0;
    qd = '0;
    case (pop_ctl_i.phase)
      gmtig_pkg::PH_INNER: begin
        qa = row_base + col_w;
        qb = qa + nv_w;
        qc = qb + AccW'(1);
        qd = qa + AccW'(1);
      end
      gmtig_pkg::PH_VWRAP: begin
        qa = row_base + nv_m1;
        qb = next_base + nv_m1;
        qc = flags_i.twist_v ? next_base : row_base;
        qd = flags_i.twist_v ? row_base : next_base;
      end
      gmtig_pkg::PH_UWRAP: begin
        qa = last_base + col_w;
        qc = qa + AccW'(1);
        if (flags_i.twist_u) begin
          qb = nv_m1 - col_w;
          qd = qb - AccW'(1);
        end else begin
          qb = col_w;
          qd = col_w + AccW'(1);
        end
      end
      default: begin
        qa = last_base + nv_m1;
        qb = flags_i.twist_u ? '0 : nv_m1;
        // The far corner is the one of the first row opposite to b.
        if (flags_i.twist_v) begin
          qc = flags_i.twist_u ? nv_m1 : '0;
          qd = last_base;
        end else begin
          qc = last_base;
          qd = flags_i.twist_u ? nv_m1 : '0;
        end
      end
    endcase
  end

  // Winding order and the exhausted case.
  always_comb begin
    if (pop_ctl_i.exh) begin
      t0f_d = '0;
      t0s_d = '0;
      t0t_d = '0;
      t1f_d = '0;
      t1s_d = '0;
      t1t_d = '0;
    end else if (flags_i.clockwise) begin
      t0f_d = IdxW'(qa);
      t0s_d = IdxW'(qb);
      t0t_d = IdxW'(qc);
      t1f_d = IdxW'(qa);
      t1s_d = IdxW'(qc);
      t1t_d = IdxW'(qd);
    end else begin
      t0f_d = IdxW'(qa);
      t0s_d = IdxW'(qc);
      t0t_d = IdxW'(qb);
      t1f_d = IdxW'(qa);
      t1s_d = IdxW'(qd);
      t1t_d = IdxW'(qc);
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      t0f_q  <= t0f_d;
      t0s_q  <= t0s_d;
      t0t_q  <= t0t_d;
      t1f_q  <= t1f_d;
      t1s_q  <= t1s_d;
      t1t_q  <= t1t_d;
      last_q <= pop_ctl_i.last && !pop_ctl_i.exh;
      exh_q  <= pop_ctl_i.exh;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = valid_q;
  assign tri0_first_o  = t0f_q;
  assign tri0_second_o = t0s_q;
  assign tri0_third_o  = t0t_q;
  assign tri1_first_o  = t1f_q;
  assign tri1_second_o = t1s_q;
  assign tri1_third_o  = t1t_q;
  assign last_o        = last_q;
  assign exhausted_o   = exh_q;

`ifndef NO_ASSERTIONS
  // An exhausted result carries zero indices and no final flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && exh_q |-> (t0f_q == '0) && (t0s_q == '0) && (t0t_q == '0) &&
      (t1f_q == '0) && (t1s_q == '0) && (t1t_q == '0) && !last_q)
    else $error("exhausted result with nonzero fields");
`endif

endmodule

>>> sv/grid_mesh_triangle_index_generator_unit.sv
// ----------------------------------------------------------------------------
// Grid mesh triangle index generator
// Walks a U-by-V point grid quad by quad and returns the six vertex indices
// of each quad's two triangles, with wrap rows, twists and winding control.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i while
//   the block is idle; cfg_ready_o is always high. Unknown indexes are ignored.
//   Each request on the input channel (restart_i = 1 starts from the first
//   quad, 0 advances) produces exactly one result on the output channel: six
//   indices, a final-quad flag and an exhausted flag once the walk is over.
//   An accepted request's quad descriptor is written into the queue and then
//   into the output register, where out_valid_o presents its result.
//   One request is accepted per cycle while in_ready_o is high; the walk
//   sequencer updates its row, column and phase counters for each request,
//   and the index calculation uses one row-base multiply per result, so the
//   sustained rate is one quad per cycle while out_ready_i stays high.
//   A two-entry queue sits between the sequencer and the output register; if
//   the receiver stalls, requests are still taken until the queue and output
//   register are full, then in_ready_o drops.
//   Reset clears the walk to the first quad and restores the register
//   defaults: 50 by 50 points, no joins, no twists, clockwise winding.
// ----------------------------------------------------------------------------
module grid_mesh_triangle_index_generator_unit #(
  parameter int unsigned MaxSide = gmtig_pkg::MaxSideDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gmtig_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gmtig_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [gmtig_pkg::IdxW-1:0]       tri0_first_o,
  output logic [gmtig_pkg::IdxW-1:0]       tri0_second_o,
  output logic [gmtig_pkg::IdxW-1:0]       tri0_third_o,
  output logic [gmtig_pkg::IdxW-1:0]       tri1_first_o,
  output logic [gmtig_pkg::IdxW-1:0]       tri1_second_o,
  output logic [gmtig_pkg::IdxW-1:0]       tri1_third_o,
  output logic                             last_o,
  output logic                             exhausted_o
);

  localparam int unsigned CntW  = $clog2(MaxSide);
  localparam int unsigned SideW = $clog2(MaxSide + 1);
  localparam int unsigned CfgW  = gmtig_pkg::CfgW;

  logic [CfgW-1:0]       points_u_q, points_v_q;
  gmtig_pkg::cfg_flags_t flags_q;
  logic [SideW-1:0]      nu, nv;

  logic                  q_push, q_pop, q_full, q_empty;
  gmtig_pkg::cmd_ctl_t   push_ctl, pop_ctl;
  logic [CntW-1:0]       push_row, push_col, pop_row, pop_col;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_u_q        <= gmtig_pkg::PointsReset;
      points_v_q        <= gmtig_pkg::PointsReset;
      flags_q.join_u    <= 1'b0;
      flags_q.join_v    <= 1'b0;
      flags_q.twist_u   <= 1'b0;
      flags_q.twist_v   <= 1'b0;
      flags_q.clockwise <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gmtig_pkg::CFG_POINTS_U:  points_u_q        <= cfg_data_i;
        gmtig_pkg::CFG_POINTS_V:  points_v_q        <= cfg_data_i;
        gmtig_pkg::CFG_JOIN_U:    flags_q.join_u    <= cfg_data_i[0];
        gmtig_pkg::CFG_JOIN_V:    flags_q.join_v    <= cfg_data_i[0];
        gmtig_pkg::CFG_TWIST_U:   flags_q.twist_u   <= cfg_data_i[0];
        gmtig_pkg::CFG_TWIST_V:   flags_q.twist_v   <= cfg_data_i[0];
        gmtig_pkg::CFG_CLOCKWISE: flags_q.clockwise <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Point counts saturated into the supported range.
  always_comb begin
    if (points_u_q < CfgW'(2)) begin
      nu = SideW'(2);
    end else if (32'(points_u_q) > 32'(MaxSide)) begin
      nu = SideW'(MaxSide);
    end else begin
      nu = SideW'(points_u_q);
    end
    if (points_v_q < CfgW'(2)) begin
      nv = SideW'(2);
    end else if (32'(points_v_q) > 32'(MaxSide)) begin
      nv = SideW'(MaxSide);
    end else begin
      nv = SideW'(points_v_q);
    end
  end

  gmtig_front #(
    .MaxSide (MaxSide)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .nu_i       (nu),
    .nv_i       (nv),
    .flags_i    (flags_q),
    .full_i     (q_full),
    .push_o     (q_push),
    .push_ctl_o (push_ctl),
    .push_row_o (push_row),
    .push_col_o (push_col)
  );

  gmtig_queue #(
    .CntW (CntW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_ctl_i (push_ctl),
    .push_row_i (push_row),
    .push_col_i (push_col),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_ctl_o  (pop_ctl),
    .pop_row_o  (pop_row),
    .pop_col_o  (pop_col),
    .empty_o    (q_empty)
  );

  gmtig_back #(
    .MaxSide (MaxSide)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nu_i          (nu),
    .nv_i          (nv),
    .flags_i       (flags_q),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .pop_ctl_i     (pop_ctl),
    .pop_row_i     (pop_row),
    .pop_col_i     (pop_col),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tri0_first_o  (tri0_first_o),
    .tri0_second_o (tri0_second_o),
    .tri0_third_o  (tri0_third_o),
    .tri1_first_o  (tri1_first_o),
    .tri1_second_o (tri1_second_o),
    .tri1_third_o  (tri1_third_o),
    .last_o        (last_o),
    .exhausted_o   (exhausted_o)
  );

endmodule
